>>> design/tbdlp_pkg.sv
package tbdlp_pkg;

  // Widths fixed by the field definitions
  localparam int TIME_WIDTH_DEF = 32;
  localparam int TIME_IN_W      = 32;
  localparam int DEB_W          = 20;
  localparam int LONG_W         = 24;
  localparam int OCT_W          = 4;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 4;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]         DEB_RST     = 20'd30000;
  localparam logic [LONG_W-1:0]        LONG_RST    = 24'd800000;
  localparam logic signed [OCT_W-1:0]  OCT_MIN_RST = -4'sd3;
  localparam logic signed [OCT_W-1:0]  OCT_MAX_RST = 4'sd3;

  // Button slots
  localparam int NUM_BTN    = 3;
  localparam int BTN_CENTER = 0;
  localparam int BTN_LEFT   = 1;
  localparam int BTN_RIGHT  = 2;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_OCT_MIN    = 2'd2,
    REG_OCT_MAX    = 2'd3
  } reg_idx_t;

endpackage

>>> design/three_button_debounce_long_press_top.sv
// Channel  Direction  Handshake         Payload
// in_      sink       in_valid/in_stall   center/left/right raw levels, time_us
// out_     source     out_valid/out_stall octave_offset, mode_toggle, pair_request,
//                                         center/left/right stable levels
// cfg      APB slave  psel/penable/pready 4 registers at byte addresses 0,4,8,12
//
// One sample per clock sustained while out_stall is low; a result shows on the
// out_ ports after passing the input register, then the result register. The
// per-sample path is one TIME_WIDTH subtract and compare per button, one more
// for the center hold, and two chained octave clamps, between those registers.
// Reset is synchronous, active low; the first sample after reset only seeds
// the raw levels, stable levels and change times.
// out_stall holds the result register; in_stall rises only when the input
// register holds a sample and the result register is full and stalled.
module three_button_debounce_long_press_top #(
  parameter int TIME_WIDTH = tbdlp_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_center_raw,
  input  logic                                 in_left_raw,
  input  logic                                 in_right_raw,
  input  logic [tbdlp_pkg::TIME_IN_W-1:0]      in_time_us,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tbdlp_pkg::OCT_W-1:0]   out_octave_offset,
  output logic                                 out_mode_toggle,
  output logic                                 out_pair_request,
  output logic                                 out_center_stable,
  output logic                                 out_left_stable,
  output logic                                 out_right_stable,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tbdlp_pkg::ADDR_W-1:0]         paddr,
  input  logic [tbdlp_pkg::DATA_W-1:0]         pwdata,
  output logic [tbdlp_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int NB = tbdlp_pkg::NUM_BTN;
  localparam int CI = tbdlp_pkg::BTN_CENTER;
  localparam int LI = tbdlp_pkg::BTN_LEFT;
  localparam int RI = tbdlp_pkg::BTN_RIGHT;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tbdlp_pkg::DEB_W-1:0]         deb_r;
  logic [tbdlp_pkg::LONG_W-1:0]        long_r;
  logic signed [tbdlp_pkg::OCT_W-1:0]  oct_min_r;
  logic signed [tbdlp_pkg::OCT_W-1:0]  oct_max_r;
  tbdlp_pkg::reg_idx_t                 reg_idx;
  logic                                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = tbdlp_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r     <= tbdlp_pkg::DEB_RST;
      long_r    <= tbdlp_pkg::LONG_RST;
      oct_min_r <= tbdlp_pkg::OCT_MIN_RST;
      oct_max_r <= tbdlp_pkg::OCT_MAX_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tbdlp_pkg::REG_DEBOUNCE:   deb_r     <= pwdata[tbdlp_pkg::DEB_W-1:0];
        tbdlp_pkg::REG_LONG_PRESS: long_r    <= pwdata[tbdlp_pkg::LONG_W-1:0];
        tbdlp_pkg::REG_OCT_MIN:    oct_min_r <= pwdata[tbdlp_pkg::OCT_W-1:0];
        tbdlp_pkg::REG_OCT_MAX:    oct_max_r <= pwdata[tbdlp_pkg::OCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbdlp_pkg::REG_DEBOUNCE:   prdata = tbdlp_pkg::DATA_W'(deb_r);
      tbdlp_pkg::REG_LONG_PRESS: prdata = tbdlp_pkg::DATA_W'(long_r);
      tbdlp_pkg::REG_OCT_MIN:    prdata = tbdlp_pkg::DATA_W'({oct_min_r});
      tbdlp_pkg::REG_OCT_MAX:    prdata = tbdlp_pkg::DATA_W'({oct_max_r});
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register -> result register
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic [NB-1:0]         s1_lv_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic                  out_valid_r;
  logic                  adv;       // input register moves into result register
  logic                  in_take;

  assign adv      = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // timestamp reduced to TIME_WIDTH bits on capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_lv_r[CI] <= in_center_raw;
      s1_lv_r[LI] <= in_left_raw;
      s1_lv_r[RI] <= in_right_raw;
      s1_now_r    <= TIME_WIDTH'(in_time_us);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Button state
  // ---------------------------------------------------------------------------
  logic                               seeded_r,  seeded_nxt;
  logic [NB-1:0]                      raw_r,     raw_nxt;
  logic [NB-1:0]                      stable_r,  stable_nxt;
  logic [TIME_WIDTH-1:0]              ct_r  [NB];
  logic [TIME_WIDTH-1:0]              ct_nxt[NB];
  logic                               held_r,    held_nxt;
  logic                               long_done_r, long_done_nxt;
  logic [TIME_WIDTH-1:0]              hold_r,    hold_nxt;
  logic signed [tbdlp_pkg::OCT_W-1:0] oct_r,     oct_nxt;
  logic                               toggle_nxt, pair_nxt;

  // Clamp a stepped value into [lo, hi]; below lo wins when bounds are inverted
  function automatic logic signed [tbdlp_pkg::OCT_W-1:0] clamp_oct(
    input logic signed [tbdlp_pkg::OCT_W:0]   v,
    input logic signed [tbdlp_pkg::OCT_W-1:0] lo,
    input logic signed [tbdlp_pkg::OCT_W-1:0] hi
  );
    logic signed [tbdlp_pkg::OCT_W-1:0] res;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v[tbdlp_pkg::OCT_W-1:0];
    end
    return res;
  endfunction

  logic [NB-1:0]                      edge_hit;
  logic [TIME_WIDTH-1:0]              elapsed[NB];
  logic [TIME_WIDTH-1:0]              hold_elapsed;
  logic signed [tbdlp_pkg::OCT_W:0]   oct_ext;
  logic signed [tbdlp_pkg::OCT_W-1:0] oct_mid;
  logic signed [tbdlp_pkg::OCT_W:0]   mid_ext;
  logic                               pressed;

  always_comb begin
    seeded_nxt    = seeded_r;
    raw_nxt       = raw_r;
    stable_nxt    = stable_r;
    held_nxt      = held_r;
    long_done_nxt = long_done_r;
    hold_nxt      = hold_r;
    oct_nxt       = oct_r;
    toggle_nxt    = 1'b0;
    pair_nxt      = 1'b0;
    edge_hit      = '0;
    for (int i = 0; i < NB; i++) begin
      ct_nxt[i]  = ct_r[i];
      elapsed[i] = '0;
    end
    hold_elapsed = s1_now_r - hold_r;
    oct_ext      = '0;
    oct_mid      = oct_r;
    mid_ext      = '0;
    pressed      = 1'b0;

    if (!seeded_r) begin
      // seed tick: adopt levels, no actions
      seeded_nxt = 1'b1;
      raw_nxt    = s1_lv_r;
      stable_nxt = s1_lv_r;
      for (int i = 0; i < NB; i++) begin
        ct_nxt[i] = s1_now_r;
      end
    end else begin
      // debounce, buttons independent
      for (int i = 0; i < NB; i++) begin
        if (s1_lv_r[i] != raw_r[i]) begin
          raw_nxt[i] = s1_lv_r[i];
          ct_nxt[i]  = s1_now_r;
        end
        elapsed[i] = s1_now_r - ct_nxt[i];
        if (stable_r[i] != raw_nxt[i] && elapsed[i] >= TIME_WIDTH'(deb_r)) begin
          stable_nxt[i] = raw_nxt[i];
          edge_hit[i]   = 1'b1;
        end
      end

      // octave: left step first, then right
      oct_ext = {oct_r[tbdlp_pkg::OCT_W-1], oct_r};
      if (edge_hit[LI] && !stable_nxt[LI]) begin
        oct_mid = clamp_oct(oct_ext - 5'sd1, oct_min_r, oct_max_r);
      end
      mid_ext = {oct_mid[tbdlp_pkg::OCT_W-1], oct_mid};
      oct_nxt = oct_mid;
      if (edge_hit[RI] && !stable_nxt[RI]) begin
        oct_nxt = clamp_oct(mid_ext + 5'sd1, oct_min_r, oct_max_r);
      end

      // center: short release toggles, long hold pairs once
      pressed = ~stable_nxt[CI];
      if (pressed && !held_r) begin
        held_nxt      = 1'b1;
        hold_nxt      = s1_now_r;
        long_done_nxt = 1'b0;
      end else if (!pressed && held_r) begin
        held_nxt   = 1'b0;
        toggle_nxt = ~long_done_r;
      end else if (pressed && held_r && !long_done_r) begin
        if (hold_elapsed >= TIME_WIDTH'(long_r)) begin
          long_done_nxt = 1'b1;
          pair_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r    <= 1'b0;
      raw_r       <= '1;
      stable_r    <= '1;
      held_r      <= 1'b0;
      long_done_r <= 1'b0;
      oct_r       <= '0;
    end else if (adv) begin
      seeded_r    <= seeded_nxt;
      raw_r       <= raw_nxt;
      stable_r    <= stable_nxt;
      held_r      <= held_nxt;
      long_done_r <= long_done_nxt;
      oct_r       <= oct_nxt;
    end
  end

  // timestamps are always written before they are read
  always_ff @(posedge clk) begin
    if (adv) begin
      hold_r <= hold_nxt;
      for (int i = 0; i < NB; i++) begin
        ct_r[i] <= ct_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_octave_offset <= oct_nxt;
      out_mode_toggle   <= toggle_nxt;
      out_pair_request  <= pair_nxt;
      out_center_stable <= stable_nxt[CI];
      out_left_stable   <= stable_nxt[LI];
      out_right_stable  <= stable_nxt[RI];
    end
  end

endmodule

>>> design/tbdlp_checker.sv
module tbdlp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [tbdlp_pkg::OCT_W-1:0] out_octave_offset,
  input logic                               out_mode_toggle,
  input logic                               out_pair_request,
  input logic                               out_center_stable,
  input logic                               out_left_stable,
  input logic                               out_right_stable
);

  // reset empties both stages
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall active after reset");

  // a toggle only comes with the center released
  a_toggle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_toggle |-> out_center_stable && !out_pair_request)
    else $error("mode toggle with center pressed or with pair request");

  // a pair request only comes while center is held
  a_pair_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pair_request |-> !out_center_stable)
    else $error("pair request with center released");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_octave_offset)
      && $stable(out_mode_toggle) && $stable(out_pair_request)
      && $stable(out_center_stable) && $stable(out_left_stable)
      && $stable(out_right_stable))
    else $error("stalled result changed");

endmodule

bind three_button_debounce_long_press_top tbdlp_checker u_tbdlp_checker (.*);

>>> bench/button_result_checker.sv
`timescale 1ns / 1ps

module button_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_center_raw,
  input  logic                                in_left_raw,
  input  logic                                in_right_raw,
  input  logic [tbdlp_pkg::TIME_IN_W-1:0]     in_time_us,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [tbdlp_pkg::OCT_W-1:0]  out_octave_offset,
  input  logic                                out_mode_toggle,
  input  logic                                out_pair_request,
  input  logic                                out_center_stable,
  input  logic                                out_left_stable,
  input  logic                                out_right_stable,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [tbdlp_pkg::ADDR_W-1:0]        paddr,
  input  logic [tbdlp_pkg::DATA_W-1:0]        pwdata,
  output int                                  err_count,
  output int                                  pending
);

  typedef struct packed {
    logic [3:0] octave;
    logic       toggle;
    logic       pair;
    logic       center;
    logic       left;
    logic       right;
  } panel_result_t;

  // register mirror
  logic [tbdlp_pkg::DEB_W-1:0]         deb_us;
  logic [tbdlp_pkg::LONG_W-1:0]        long_us;
  logic signed [tbdlp_pkg::OCT_W-1:0]  oct_lo;
  logic signed [tbdlp_pkg::OCT_W-1:0]  oct_hi;

  // button state
  logic [2:0]                          raw_lv;
  logic [2:0]                          stab_lv;
  logic [31:0]                         chg_t [3];
  logic                                held;
  logic                                long_hit;
  logic                                seeded;
  logic [31:0]                         hold_t;
  logic signed [tbdlp_pkg::OCT_W-1:0]  octave;

  panel_result_t panel_q [$];

  task automatic report(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic logic signed [3:0] clamp_octave(input int v);
    if (v < int'(oct_lo)) return oct_lo;
    if (v > int'(oct_hi)) return oct_hi;
    return 4'(v);
  endfunction

  // raw change restarts the timer; stable follows after the hold time
  function automatic logic settle(input int b, input logic lv, input logic [31:0] now);
    if (lv != raw_lv[b]) begin
      raw_lv[b] = lv;
      chg_t[b]  = now;
    end
    if (stab_lv[b] != raw_lv[b] && 32'(now - chg_t[b]) >= {12'd0, deb_us}) begin
      stab_lv[b] = raw_lv[b];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic advance_buttons(input logic [2:0] lv, input logic [31:0] now,
                                 output panel_result_t res);
    logic l_edge;
    logic r_edge;
    logic pressed;
    res = '0;
    if (!seeded) begin
      raw_lv  = lv;
      stab_lv = lv;
      for (int b = 0; b < 3; b++) chg_t[b] = now;
      seeded = 1'b1;
    end else begin
      void'(settle(tbdlp_pkg::BTN_CENTER, lv[tbdlp_pkg::BTN_CENTER], now));
      l_edge = settle(tbdlp_pkg::BTN_LEFT, lv[tbdlp_pkg::BTN_LEFT], now);
      r_edge = settle(tbdlp_pkg::BTN_RIGHT, lv[tbdlp_pkg::BTN_RIGHT], now);
      // left before right
      if (l_edge && !stab_lv[tbdlp_pkg::BTN_LEFT])
        octave = clamp_octave(int'(octave) - 1);
      if (r_edge && !stab_lv[tbdlp_pkg::BTN_RIGHT])
        octave = clamp_octave(int'(octave) + 1);
      pressed = !stab_lv[tbdlp_pkg::BTN_CENTER];
      if (pressed && !held) begin
        held     = 1'b1;
        hold_t   = now;
        long_hit = 1'b0;
      end else if (!pressed && held) begin
        held = 1'b0;
        if (!long_hit) res.toggle = 1'b1;
      end else if (pressed && held && !long_hit &&
                   32'(now - hold_t) >= {8'd0, long_us}) begin
        long_hit = 1'b1;
        res.pair = 1'b1;
      end
    end
    res.octave = octave;
    res.center = stab_lv[tbdlp_pkg::BTN_CENTER];
    res.left   = stab_lv[tbdlp_pkg::BTN_LEFT];
    res.right  = stab_lv[tbdlp_pkg::BTN_RIGHT];
  endtask

  always @(posedge clk) begin
    panel_result_t want;
    panel_result_t got;
    if (!rst_n) begin
      deb_us    = tbdlp_pkg::DEB_RST;
      long_us   = tbdlp_pkg::LONG_RST;
      oct_lo    = tbdlp_pkg::OCT_MIN_RST;
      oct_hi    = tbdlp_pkg::OCT_MAX_RST;
      raw_lv    = 3'b111;
      stab_lv   = 3'b111;
      for (int b = 0; b < 3; b++) chg_t[b] = '0;
      held      = 1'b0;
      long_hit  = 1'b0;
      seeded    = 1'b0;
      hold_t    = '0;
      octave    = '0;
      err_count = 0;
      panel_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (tbdlp_pkg::reg_idx_t'(paddr[3:2]))
          tbdlp_pkg::REG_DEBOUNCE:   deb_us  = pwdata[tbdlp_pkg::DEB_W-1:0];
          tbdlp_pkg::REG_LONG_PRESS: long_us = pwdata[tbdlp_pkg::LONG_W-1:0];
          tbdlp_pkg::REG_OCT_MIN:    oct_lo  = pwdata[tbdlp_pkg::OCT_W-1:0];
          tbdlp_pkg::REG_OCT_MAX:    oct_hi  = pwdata[tbdlp_pkg::OCT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_buttons({in_right_raw, in_left_raw, in_center_raw}, in_time_us, want);
        panel_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (panel_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = panel_q.pop_front();
          got  = '{out_octave_offset, out_mode_toggle, out_pair_request,
                   out_center_stable, out_left_stable, out_right_stable};
          check_field("octave_offset", got.octave, want.octave);
          check_field("mode_toggle",   got.toggle, want.toggle);
          check_field("pair_request",  got.pair,   want.pair);
          check_field("center_stable", got.center, want.center);
          check_field("left_stable",   got.left,   want.left);
          check_field("right_stable",  got.right,  want.right);
        end
      end
    end
    pending = panel_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  // generous ceiling; the slowest legal run is far below this
  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst_n = 1'b0;

  // sample channel
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        in_center_raw = 1'b1;
  logic        in_left_raw   = 1'b1;
  logic        in_right_raw  = 1'b1;
  logic [tbdlp_pkg::TIME_IN_W-1:0] in_time_us = '0;

  // result channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [tbdlp_pkg::OCT_W-1:0] out_octave_offset;
  logic        out_mode_toggle;
  logic        out_pair_request;
  logic        out_center_stable;
  logic        out_left_stable;
  logic        out_right_stable;

  // config port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [tbdlp_pkg::ADDR_W-1:0] paddr  = '0;
  logic [tbdlp_pkg::DATA_W-1:0] pwdata = '0;
  logic [tbdlp_pkg::DATA_W-1:0] prdata;
  logic        pready;

  int          err_count;
  int          pending;

  // sender bookkeeping: running timestamp and the level each button is "meant" to hold
  logic [31:0] stamp;
  logic [2:0]  btn_target = 3'b111;

  three_button_debounce_long_press_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_center_raw     (in_center_raw),
    .in_left_raw       (in_left_raw),
    .in_right_raw      (in_right_raw),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_octave_offset (out_octave_offset),
    .out_mode_toggle   (out_mode_toggle),
    .out_pair_request  (out_pair_request),
    .out_center_stable (out_center_stable),
    .out_left_stable   (out_left_stable),
    .out_right_stable  (out_right_stable),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  button_result_checker i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_center_raw     (in_center_raw),
    .in_left_raw       (in_left_raw),
    .in_right_raw      (in_right_raw),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_octave_offset (out_octave_offset),
    .out_mode_toggle   (out_mode_toggle),
    .out_pair_request  (out_pair_request),
    .out_center_stable (out_center_stable),
    .out_left_stable   (out_left_stable),
    .out_right_stable  (out_right_stable),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .err_count         (err_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length between sample transfers: mostly back to back, now and then a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one sample and hold it until the transfer happens. lv is {right, left, center}.
  // valid is only lowered for a gap, so it never sees two updates in one step.
  task automatic offer(input logic [2:0] lv, input logic [31:0] t, input bit steady = 1'b0);
    int gap;
    in_valid      <= 1'b1;
    in_center_raw <= lv[tbdlp_pkg::BTN_CENTER];
    in_left_raw   <= lv[tbdlp_pkg::BTN_LEFT];
    in_right_raw  <= lv[tbdlp_pkg::BTN_RIGHT];
    in_time_us    <= t;
    do @(posedge clk); while (in_stall);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic set_reg(input tbdlp_pkg::reg_idx_t idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int deb, input int lng, input int lo, input int hi);
    set_reg(tbdlp_pkg::REG_DEBOUNCE, deb);
    set_reg(tbdlp_pkg::REG_LONG_PRESS, lng);
    set_reg(tbdlp_pkg::REG_OCT_MIN, lo);
    set_reg(tbdlp_pkg::REG_OCT_MAX, hi);
  endtask

  // Stop offering and wait for every predicted result to come out. The count is
  // sampled on the falling edge so it is never read mid-update.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // pipeline is two deep; a few spare cycles before touching registers
    repeat (4) @(posedge clk);
  endtask

  // Mostly realistic button activity: each button follows a target level that flips
  // now and then, with occasional contact bounce. Timestamp steps are scaled to the
  // current debounce time so edges actually settle. A small share is pure noise
  // with arbitrary levels and timestamp jumps.
  task automatic run_random(input int count, input int deb, input int lng);
    int k;
    int b;
    int r;
    int span;
    logic [2:0] lv;
    span = (deb > 0) ? deb : 8;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        lv    = 3'($urandom);
        stamp = $urandom;
      end else begin
        for (b = 0; b < 3; b++) begin
          // center flips less often so long presses get a chance
          if ($urandom_range(0, 99) < ((b == tbdlp_pkg::BTN_CENTER) ? 7 : 12))
            btn_target[b] = ~btn_target[b];
          lv[b] = ($urandom_range(0, 99) < 8) ? ~btn_target[b] : btn_target[b];
        end
        r = $urandom_range(0, 19);
        if (r < 8)       stamp += $urandom_range(0, span / 4);
        else if (r < 16) stamp += $urandom_range(span / 2, span * 2);
        else if (r < 19) stamp += $urandom_range(span, lng + span);
        else             stamp += $urandom;
      end
      // first quarter of every hundred goes back to back
      offer(lv, stamp, (k % 100) < 25);
    end
  endtask

  // Receiver pacing: short stalls, free-running stretches, now and then a longer
  // stall, and periodically a long hold-off so the block fills up and pushes back
  // on the sender.
  initial begin : rx_pacing
    int seg_no;
    int seg_len;
    int r;
    logic v;
    seg_no = 0;
    @(posedge clk);
    forever begin
      seg_no++;
      if (seg_no % 50 == 5) begin
        v       = 1'b1;
        seg_len = 400;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          v       = 1'b1;
          seg_len = $urandom_range(20, 60);
        end else if (r < 45) begin
          v       = 1'b1;
          seg_len = $urandom_range(1, 4);
        end else if (r < 92) begin
          v       = 1'b0;
          seg_len = $urandom_range(1, 3);
        end else begin
          v       = 1'b0;
          seg_len = $urandom_range(10, 40);
        end
      end
      out_stall <= v;
      repeat (seg_len) @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int rd_deb;
    int rd_long;
    int rd_lo;
    int rd_hi;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset register values (30 ms debounce, 0.8 s long press) ----
    // start just below the timestamp wrap so the first hold times cross it
    stamp = 32'hFFFF_F000;
    offer(3'b111, stamp);                     // seed tick: no action, no pulses
    stamp += 10;     offer(3'b101, stamp);    // left goes down
    stamp += 10;     offer(3'b111, stamp);    // bounce back up
    stamp += 10;     offer(3'b101, stamp);    // down again, timer restarts
    stamp += 29999;  offer(3'b101, stamp);    // one short of the hold time, across the wrap
    stamp += 1;      offer(3'b101, stamp);    // exactly the hold time: octave steps down
    stamp += 50;     offer(3'b111, stamp);
    stamp += 30000;  offer(3'b111, stamp);    // left released
    stamp += 50;     offer(3'b001, stamp);    // left and right together
    stamp += 30000;  offer(3'b001, stamp);    // both settle in one tick, left applied first
    stamp += 50;     offer(3'b111, stamp);
    stamp += 30000;  offer(3'b111, stamp);
    stamp += 50;     offer(3'b110, stamp);    // short center press
    stamp += 30000;  offer(3'b110, stamp);
    stamp += 50;     offer(3'b111, stamp);
    stamp += 30000;  offer(3'b111, stamp);    // release: mode toggle
    stamp += 50;     offer(3'b110, stamp);    // long center press
    stamp += 30000;  offer(3'b110, stamp);
    stamp += 799999; offer(3'b110, stamp);    // just short of the long-press time
    stamp += 1;      offer(3'b110, stamp);    // pairing pulse
    stamp += 100;    offer(3'b111, stamp);
    stamp += 30000;  offer(3'b111, stamp);    // release after long press: no toggle
    offer(3'b000, 32'h0000_0000);             // timestamp extremes, all buttons at once
    offer(3'b111, 32'hFFFF_FFFF);
    stamp = 32'hFFFF_FFFF;

    // ---- random phases, registers only touched once the pipe is empty ----
    drain();
    run_random(300, 30000, 800000);

    // zero hold times, widest bounds
    drain();
    apply_setting(0, 0, -8, 7);
    run_random(300, 0, 0);

    // long hold times, inverted bounds
    drain();
    apply_setting(1000000, 10000000, 7, -8);
    run_random(300, 1000000, 10000000);

    // short times, narrow bounds (octave may sit outside them until the next step)
    drain();
    apply_setting(16, 300, -2, 1);
    run_random(300, 16, 300);

    drain();
    rd_deb  = $urandom_range(0, 5000);
    rd_long = $urandom_range(0, 100000);
    rd_lo   = $urandom_range(0, 15) - 8;
    rd_hi   = $urandom_range(0, 15) - 8;
    apply_setting(rd_deb, rd_long, rd_lo, rd_hi);
    run_random(300, rd_deb, rd_long);

    // collapsed bounds, long press out of reach in practice
    drain();
    apply_setting(5, 10000000, 0, 0);
    run_random(300, 5, 10000000);

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
